// ===== rtl/sti_pkg.sv =====
// Package for the sorted insertion table: sizes, codes and beat types.
`default_nettype none
package sti_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [8:0]         entry_count;
  } out_item_t;

  // per-cell control for one operation
  typedef struct packed {
    logic               ins;    // insert this cycle
    logic               shift;  // remove: take right neighbor
    logic               occ;    // cell holds a live entry
    logic signed [31:0] value;  // value being inserted
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_table_insert_remove_read_top.sv =====
// Sorted insertion table: a row of compare-and-shift cells plus count and result register.
//
// Usage:
//   in_valid/in_stall/in_data carry one operation per beat: insert a signed
//   value in ascending place (after equal ones), remove the entry at a
//   position, or read the entry at a position. Each accepted beat gives one
//   result beat on out_valid/out_stall/out_data with the read value, a status
//   (ok, position out of range, table full) and the entry count afterwards.
//   The result is registered at the edge that accepts the operation.
//   Throughput is one operation per cycle while the receiver does not stall;
//   every cell compares and shifts in parallel in that same cycle.
//   While the receiver stalls, the result register holds its beat and in_stall
//   is raised, so at most one result is pending.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result; cell contents are not cleared, only the count.
`default_nettype none
module sorted_table_insert_remove_read_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sti_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sti_pkg::out_item_t      out_data
);

  localparam int D = sti_pkg::DEPTH;

  logic [sti_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sti_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      full;
  logic                      pos_ok;
  logic                      do_ins;
  logic                      do_rem;
  logic [8:0]                count_w, pos_w;

  sti_pkg::cell_ctrl_t       ctrl   [D];
  logic                      flags  [D];
  logic signed [31:0]        vals   [D];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign count_w = 9'(count_r);
  assign pos_w   = {1'b0, in_data.position};
  assign full    = (count_w == 9'(D));
  assign pos_ok  = (pos_w < count_w);
  assign do_ins  = in_acc && (in_data.mode == sti_pkg::MODE_INSERT) && !full;
  assign do_rem  = in_acc && (in_data.mode == sti_pkg::MODE_REMOVE) && pos_ok;

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign ctrl[i].ins   = do_ins;
    assign ctrl[i].shift = do_rem && (9'(i) >= pos_w);
    assign ctrl[i].occ   = 9'(i) < count_w;
    assign ctrl[i].value = in_data.value;

    if (i == 0) begin : g_first
      if (D > 1) begin : g_more
        sti_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl[i]),
          .left_flag (1'b0),
          .left_val  (vals[i]),
          .right_val (vals[i+1]),
          .flag      (flags[i]),
          .val       (vals[i])
        );
      end else begin : g_one
        sti_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl[i]),
          .left_flag (1'b0),
          .left_val  (vals[i]),
          .right_val (vals[i]),
          .flag      (flags[i]),
          .val       (vals[i])
        );
      end
    end else if (i == D - 1) begin : g_last
      sti_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[i]),
        .left_flag (flags[i-1]),
        .left_val  (vals[i-1]),
        .right_val (vals[i]),
        .flag      (flags[i]),
        .val       (vals[i])
      );
    end else begin : g_mid
      sti_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[i]),
        .left_flag (flags[i-1]),
        .left_val  (vals[i-1]),
        .right_val (vals[i+1]),
        .flag      (flags[i]),
        .val       (vals[i])
      );
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.read_value = '0;
      out_data_nxt.status     = sti_pkg::ST_OK;
      case (in_data.mode)
        sti_pkg::MODE_INSERT: begin
          if (full) begin
            out_data_nxt.status = sti_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        sti_pkg::MODE_REMOVE: begin
          if (!pos_ok) begin
            out_data_nxt.status = sti_pkg::ST_RANGE;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        sti_pkg::MODE_READ: begin
          if (!pos_ok) begin
            out_data_nxt.status = sti_pkg::ST_RANGE;
          end else begin
            out_data_nxt.read_value = vals[in_data.position[sti_pkg::IDX_W-1:0]];
          end
        end
        default: begin
        end
      endcase
      out_data_nxt.entry_count = 9'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    9'(count_r) <= 9'(D))
    else $error("entry count above depth");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("entry count changed without an accepted beat");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == sti_pkg::ST_FULL) |->
      (out_data_r.entry_count == 9'(D)))
    else $error("full status with table not full");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != sti_pkg::ST_OK) |->
      (out_data_r.read_value == '0))
    else $error("nonzero read value on error status");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.entry_count == 9'(count_r)))
    else $error("result count differs from table count");

endmodule
`default_nettype wire

// ===== rtl/sti_cell.sv =====
// One storage cell of the sorted table: compare against the new value and shift.
`default_nettype none
module sti_cell (
  input  wire logic               clk,
  input  wire sti_pkg::cell_ctrl_t ctrl,
  input  wire logic               left_flag,
  input  wire logic signed [31:0] left_val,
  input  wire logic signed [31:0] right_val,
  output logic                    flag,
  output logic signed [31:0]      val
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // set from the insertion slot onward; empty cells always count as greater
  assign flag = ctrl.occ ? (val_r > ctrl.value) : 1'b1;
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (left_flag) begin
        val_nxt = left_val;
      end else if (flag) begin
        val_nxt = ctrl.value;
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the sorted insertion table: random insert/remove/read traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct {
    sti_pkg::in_item_t beat;
    int                gap;    // idle cycles before this beat is offered
    bit                drain;  // wait for all results before offering
  } pending_op_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sti_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sti_pkg::out_item_t out_data;

  sorted_table_insert_remove_read_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  pending_op_t        pending_ops[$];
  sti_pkg::out_item_t expected_results[$];

  // shadow copy of the table
  logic signed [31:0] shadow_entries [sti_pkg::DEPTH];
  int                 shadow_count = 0;

  int queued_ops = 0;
  int gen_count = 0;
  int errors = 0;
  int results_seen = 0;

  bit offering = 1'b0;
  bit beat_sent = 1'b0;
  int idle_left = 0;
  bit result_taken = 1'b0;
  int rx_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic sti_pkg::out_item_t predict_table_result(sti_pkg::in_item_t op);
    sti_pkg::out_item_t r;
    int slot;
    r = '0;
    r.status = sti_pkg::ST_OK;
    case (op.mode)
      sti_pkg::MODE_INSERT: begin
        if (shadow_count >= sti_pkg::DEPTH) begin
          r.status = sti_pkg::ST_FULL;
        end else begin
          // new value lands after any equal entries
          slot = 0;
          while (slot < shadow_count && shadow_entries[slot] <= op.value) slot++;
          for (int i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[slot] = op.value;
          shadow_count++;
        end
      end
      sti_pkg::MODE_REMOVE: begin
        if (op.position >= shadow_count) begin
          r.status = sti_pkg::ST_RANGE;
        end else begin
          for (int i = op.position; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      sti_pkg::MODE_READ: begin
        if (op.position >= shadow_count) r.status = sti_pkg::ST_RANGE;
        else r.read_value = shadow_entries[op.position];
      end
      default: ;
    endcase
    r.entry_count = 9'(shadow_count);
    return r;
  endfunction

  task automatic queue_op(input logic [1:0] mode, input logic [31:0] value,
                          input logic [7:0] pos, input bit drain);
    pending_op_t p;
    p.beat.mode     = mode;
    p.beat.value    = value;
    p.beat.position = pos;
    p.drain         = drain;
    p.gap           = ((queued_ops / 100) % 3 == 2) ? 0 : $urandom_range(0, 17);
    pending_ops.push_back(p);
    queued_ops++;
    case (mode)
      sti_pkg::MODE_INSERT: if (gen_count < sti_pkg::DEPTH) gen_count++;
      sti_pkg::MODE_REMOVE: if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // driver: offers pending beats at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (beat_sent) begin
        beat_sent = 1'b0;
        offering  = 1'b0;
        if (pending_ops.size() > 0) idle_left = pending_ops[0].gap;
      end
      if (!offering) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && expected_results.size() > 0)) begin
          in_data <= pending_ops[0].beat;
          pending_ops.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // receiver stall pattern, plus one long hold to back up the input side
  always @(negedge clk) begin
    if (rst_n) begin
      if (result_taken) begin
        result_taken = 1'b0;
        rx_wait = ((results_seen / 90) % 3 == 1) ? 0 : $urandom_range(0, 17);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  // monitor: predicts on accepted input beats, checks accepted result beats
  always @(posedge clk) begin
    sti_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_table_result(in_data));
        beat_sent = 1'b1;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        result_taken = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result beat with no pending expectation");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data.entry_count);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int sel;
    int vsel;
    int ins_pct;
    logic [31:0] v;
    logic [7:0] pos;
    logic [1:0] md;

    // directed: empty table, extremes, duplicates, full table, edges of range
    queue_op(sti_pkg::MODE_READ, 32'd0, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_REMOVE, 32'd0, 8'd0, 1'b0);
    queue_op(MODE_UNUSED, 32'hdead_beef, 8'hff, 1'b0);
    queue_op(sti_pkg::MODE_INSERT, 32'h8000_0000, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_INSERT, 32'h7fff_ffff, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_INSERT, 32'd0, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_INSERT, 32'hffff_ffff, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_INSERT, 32'd0, 8'd0, 1'b0);
    while (gen_count < sti_pkg::DEPTH) queue_op(sti_pkg::MODE_INSERT, $urandom, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_INSERT, 32'd5, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_READ, 32'd0, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_READ, 32'd0, 8'(sti_pkg::DEPTH - 1), 1'b0);
    queue_op(sti_pkg::MODE_READ, 32'd0, 8'(sti_pkg::DEPTH), 1'b0);
    queue_op(sti_pkg::MODE_REMOVE, 32'd0, 8'(sti_pkg::DEPTH - 1), 1'b0);
    queue_op(sti_pkg::MODE_REMOVE, 32'd0, 8'd0, 1'b0);
    queue_op(sti_pkg::MODE_REMOVE, 32'd0, 8'hff, 1'b0);

    for (int k = 0; k < 1200; k++) begin
      vsel = $urandom_range(0, 9);
      if (vsel < 4) v = $urandom_range(0, 15) - 8;  // narrow range -> duplicates
      else if (vsel == 4) v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      else v = $urandom;
      if (gen_count > 0 && $urandom_range(0, 9) != 0) pos = 8'($urandom_range(0, gen_count - 1));
      else pos = 8'($urandom_range(0, 255));
      ins_pct = (gen_count < 4) ? 70 : (gen_count > sti_pkg::DEPTH - 3) ? 30 : 45;
      sel = $urandom_range(0, 99);
      if (sel < 2) md = MODE_UNUSED;
      else if (sel < 2 + ins_pct) md = sti_pkg::MODE_INSERT;
      else if (sel % 2 == 0) md = sti_pkg::MODE_REMOVE;
      else md = sti_pkg::MODE_READ;
      queue_op(md, v, pos, (k % 300) == 150);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || offering || expected_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
